// ===== rtl/core/circle_canvas_painter_defines.svh =====
// ----------------------------------------------------------------------------
// Circle canvas painter assertion macros
// Clocked property shorthands used by the checker file of the painter.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_CANVAS_PAINTER_DEFINES_SVH
`define CIRCLE_CANVAS_PAINTER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define CCP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CCP_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle canvas painter package
// Field widths, register indexes, item and status codes, and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package ccp_pkg;

	localparam int MAX_SIDE_DEF = 256;

	localparam int REG_W  = 9;
	localparam int IDX_W  = 2;
	localparam int BG_W   = 7;
	localparam int CRD_W  = 21;
	localparam int R_W    = 20;
	localparam int PIX_W  = 8;
	localparam int FRAC_W = 8;
	localparam int ONE_Q8 = 256;
	localparam int IN_W   = 96;
	localparam int OUT_W  = 16;
	localparam int OP_W   = 22;
	localparam int SQ_W   = 44;
	localparam int CMP_W  = 11;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_BG     = 2'd2;

	localparam logic [REG_W-1:0] RST_WIDTH  = 9'd256;
	localparam logic [REG_W-1:0] RST_HEIGHT = 9'd256;
	localparam logic [BG_W-1:0]  RST_BG     = 7'd32;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;
	localparam logic [1:0] ST_OUTSIDE = 2'd3;

	localparam logic [PIX_W-1:0] CHAR_OUTLINE = 8'h63;
	localparam logic [PIX_W-1:0] CHAR_FILLED  = 8'h43;

	typedef logic [2:0] ccp_op_t;

	localparam ccp_op_t OP_NONE  = 3'd0;
	localparam ccp_op_t OP_OUTER = 3'd1;
	localparam ccp_op_t OP_INNER = 3'd2;
	localparam ccp_op_t OP_DY2   = 3'd3;
	localparam ccp_op_t OP_PIXEL = 3'd4;
	localparam ccp_op_t OP_FILL  = 3'd5;

	typedef struct packed {
		ccp_op_t    op;
		logic       item_load;
		logic       scan_init;
		logic       set_err;
		logic       clr_err;
		logic       rd_en;
		logic       pix_load;
		logic       res_load;
		logic [1:0] res_status;
		logic       use_pix;
	} ccp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       err;
		logic       shape_ok;
		logic       radius_zero;
		logic       side_zero;
		logic       outside;
		logic       last_col;
		logic       last_row;
		logic       pipe_busy;
	} ccp_stat_t;

endpackage

// ===== rtl/core/ccp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/ccp_datapath.sv =====
// ----------------------------------------------------------------------------
// Circle canvas painter datapath
// Configuration and item registers, scan counters, a three-stage squared
// distance pipeline, the canvas memory and the result register.
// ----------------------------------------------------------------------------
module ccp_datapath #(
	parameter int MAX_SIDE = ccp_pkg::MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ccp_pkg::IN_W-1:0]      s_tdata,
	input  logic                          cfg_wen,
	input  logic [ccp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [ccp_pkg::REG_W-1:0]     cfg_data,
	input  ccp_pkg::ccp_cmd_t             cmd,
	output ccp_pkg::ccp_stat_t            stat,
	output logic [ccp_pkg::OUT_W-1:0]     m_tdata
);

	localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OP_W  = ccp_pkg::OP_W;
	localparam int SQ_W  = ccp_pkg::SQ_W;
	localparam int CMP_W = ccp_pkg::CMP_W;

	logic [ccp_pkg::REG_W-1:0] width_q, height_q;
	logic [ccp_pkg::BG_W-1:0]  bg_q;
	logic                      err_q;

	logic [1:0]                       kind_q;
	logic [ccp_pkg::PIX_W-1:0]        shape_q, ch_q, col_q, row_q;
	logic signed [ccp_pkg::CRD_W-1:0] cx_q, cy_q;
	logic [ccp_pkg::R_W-1:0]          r_q;

	logic [ccp_pkg::REG_W-1:0] w_use, h_use;
	logic [XW-1:0]             x_q, y_q;
	logic [AW-1:0]             addr_q, rbase_q;

	logic signed [OP_W-1:0] diff;
	logic [OP_W-1:0]        mag;
	ccp_pkg::ccp_op_t       tag_s1, tag_s2;
	logic [OP_W-1:0]        mag_s1;
	logic [AW-1:0]          addr_s1, addr_s2;
	logic [SQ_W-1:0]        sq_s2;
	logic [SQ_W-1:0]        outer_q, inner_q, dy2_q, d2;
	logic                   has_inner, filled, hit;

	logic                      wr_en;
	logic [ccp_pkg::PIX_W-1:0] wr_data;
	logic [AW-1:0]             rd_addr;
	logic [ccp_pkg::PIX_W-1:0] rd_data;
	logic [ccp_pkg::PIX_W-1:0] pix_q, res_pixel_q;
	logic [1:0]                res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ccp_pkg::RST_WIDTH;
			height_q <= ccp_pkg::RST_HEIGHT;
			bg_q     <= ccp_pkg::RST_BG;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ccp_pkg::REG_WIDTH:  width_q  <= cfg_data;
				ccp_pkg::REG_HEIGHT: height_q <= cfg_data;
				ccp_pkg::REG_BG:     bg_q     <= cfg_data[ccp_pkg::BG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (cmd.set_err) begin
			err_q <= 1'b1;
		end else if (cmd.clr_err) begin
			err_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q  <= s_tdata[1:0];
			shape_q <= s_tdata[9:2];
			cx_q    <= s_tdata[30:10];
			cy_q    <= s_tdata[51:31];
			r_q     <= s_tdata[71:52];
			ch_q    <= s_tdata[79:72];
			col_q   <= s_tdata[87:80];
			row_q   <= s_tdata[95:88];
		end
	end

	assign w_use = (CMP_W'(width_q) > CMP_W'(MAX_SIDE)) ?
		ccp_pkg::REG_W'(MAX_SIDE) : width_q;
	assign h_use = (CMP_W'(height_q) > CMP_W'(MAX_SIDE)) ?
		ccp_pkg::REG_W'(MAX_SIDE) : height_q;

	assign stat.kind        = kind_q;
	assign stat.err         = err_q;
	assign stat.shape_ok    = (shape_q == ccp_pkg::CHAR_OUTLINE) ||
		(shape_q == ccp_pkg::CHAR_FILLED);
	assign stat.radius_zero = (r_q == '0);
	assign stat.side_zero   = (w_use == '0) || (h_use == '0);
	assign stat.outside     = (CMP_W'(col_q) >= CMP_W'(w_use)) ||
		(CMP_W'(row_q) >= CMP_W'(h_use));
	assign stat.last_col    = (CMP_W'(x_q) == CMP_W'(w_use) - CMP_W'(1));
	assign stat.last_row    = (CMP_W'(y_q) == CMP_W'(h_use) - CMP_W'(1));
	assign stat.pipe_busy   = (tag_s1 != ccp_pkg::OP_NONE) || (tag_s2 != ccp_pkg::OP_NONE);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			x_q     <= '0;
			y_q     <= '0;
			addr_q  <= '0;
			rbase_q <= '0;
		end else if ((cmd.op == ccp_pkg::OP_PIXEL) || (cmd.op == ccp_pkg::OP_FILL)) begin
			if (stat.last_col) begin
				x_q     <= '0;
				y_q     <= y_q + 1'b1;
				rbase_q <= rbase_q + AW'(MAX_SIDE);
				addr_q  <= rbase_q + AW'(MAX_SIDE);
			end else begin
				x_q    <= x_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// Stage 1 forms the signed offset of the operand and takes its magnitude.
	always_comb begin
		unique case (cmd.op)
			ccp_pkg::OP_OUTER: diff = OP_W'($signed({1'b0, r_q}));
			ccp_pkg::OP_INNER: diff = OP_W'($signed({1'b0, r_q})) - OP_W'(ccp_pkg::ONE_Q8);
			ccp_pkg::OP_DY2:   diff = OP_W'($signed({1'b0, y_q, {ccp_pkg::FRAC_W{1'b0}}}))
				- OP_W'(cy_q);
			ccp_pkg::OP_PIXEL: diff = OP_W'($signed({1'b0, x_q, {ccp_pkg::FRAC_W{1'b0}}}))
				- OP_W'(cx_q);
			default:           diff = '0;
		endcase
	end

	assign mag = diff[OP_W-1] ? -diff : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= ccp_pkg::OP_NONE;
			tag_s2 <= ccp_pkg::OP_NONE;
		end else begin
			tag_s1 <= cmd.op;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag;
		addr_s1 <= addr_q;
		sq_s2   <= mag_s1 * mag_s1;
		addr_s2 <= addr_s1;
	end

	// Stage 3 loads the circle bounds or the row term, or tests one pixel and writes it, or writes a fill pixel.
	assign d2        = sq_s2 + dy2_q;
	assign has_inner = (r_q >= ccp_pkg::R_W'(ccp_pkg::ONE_Q8));
	assign filled    = (shape_q == ccp_pkg::CHAR_FILLED);
	assign hit       = (d2 <= outer_q) && (filled || !has_inner || (d2 > inner_q));

	always_ff @(posedge clk) begin
		if (tag_s2 == ccp_pkg::OP_OUTER) begin
			outer_q <= sq_s2;
		end
		if (tag_s2 == ccp_pkg::OP_INNER) begin
			inner_q <= sq_s2;
		end
		if (tag_s2 == ccp_pkg::OP_DY2) begin
			dy2_q <= sq_s2;
		end
	end

	assign wr_en   = ((tag_s2 == ccp_pkg::OP_PIXEL) && hit) || (tag_s2 == ccp_pkg::OP_FILL);
	assign wr_data = (tag_s2 == ccp_pkg::OP_FILL) ? ccp_pkg::PIX_W'(bg_q) : ch_q;
	assign rd_addr = AW'(row_q) * AW'(MAX_SIDE) + AW'(col_q);

	ccp_ram #(
		.WIDTH (ccp_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_canvas (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s2),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.pix_load) begin
			pix_q <= rd_data;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_pixel_q  <= cmd.use_pix ? pix_q : '0;
		end
	end

	assign m_tdata = {{(ccp_pkg::OUT_W - ccp_pkg::PIX_W - 2){1'b0}}, res_pixel_q, res_status_q};

endmodule

// ===== rtl/core/ccp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Circle canvas painter controller
// Sequences one item at a time: decode, circle setup, row and pixel scan,
// pipeline drain, pixel read and the hand-off to the output register.
// ----------------------------------------------------------------------------
module ccp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  ccp_pkg::ccp_stat_t stat,
	output ccp_pkg::ccp_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_SETUP_R = 4'd2;
	localparam logic [3:0] S_SETUP_I = 4'd3;
	localparam logic [3:0] S_ROW     = 4'd4;
	localparam logic [3:0] S_PIX     = 4'd5;
	localparam logic [3:0] S_DRAIN   = 4'd6;
	localparam logic [3:0] S_RD_DATA = 4'd7;
	localparam logic [3:0] S_RESULT  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       fill_q, fill_d;
	logic [1:0] status_q, status_d;
	logic       use_pix_q, use_pix_d;
	logic       out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.res_status = status_q;
		cmd.use_pix    = use_pix_q;
		state_d        = state_q;
		fill_d         = fill_q;
		status_d       = status_q;
		use_pix_d      = use_pix_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				status_d  = ccp_pkg::ST_OK;
				use_pix_d = 1'b0;
				state_d   = S_RESULT;
				priority case (stat.kind)
					ccp_pkg::KIND_CLEAR: begin
						cmd.clr_err = 1'b1;
						if (!stat.side_zero) begin
							cmd.scan_init = 1'b1;
							fill_d        = 1'b1;
							state_d       = S_ROW;
						end
					end
					ccp_pkg::KIND_DRAW: begin
						if (stat.err) begin
							status_d = ccp_pkg::ST_IGNORED;
						end else if (!stat.shape_ok || stat.radius_zero) begin
							cmd.set_err = 1'b1;
							status_d    = ccp_pkg::ST_INVALID;
						end else begin
							cmd.scan_init = 1'b1;
							fill_d        = 1'b0;
							state_d       = S_SETUP_R;
						end
					end
					ccp_pkg::KIND_READ: begin
						if (stat.outside) begin
							status_d = ccp_pkg::ST_OUTSIDE;
						end else begin
							cmd.rd_en = 1'b1;
							use_pix_d = 1'b1;
							state_d   = S_RD_DATA;
						end
					end
					default: ;
				endcase
			end
			S_SETUP_R: begin
				cmd.op  = ccp_pkg::OP_OUTER;
				state_d = S_SETUP_I;
			end
			S_SETUP_I: begin
				cmd.op  = ccp_pkg::OP_INNER;
				state_d = stat.side_zero ? S_DRAIN : S_ROW;
			end
			S_ROW: begin
				cmd.op  = ccp_pkg::OP_DY2;
				state_d = S_PIX;
			end
			S_PIX: begin
				cmd.op = fill_q ? ccp_pkg::OP_FILL : ccp_pkg::OP_PIXEL;
				if (stat.last_col) begin
					state_d = stat.last_row ? S_DRAIN : S_ROW;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = S_RESULT;
				end
			end
			S_RD_DATA: begin
				cmd.pix_load = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || m_tready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= 1'b0;
			status_q    <= ccp_pkg::ST_OK;
			use_pix_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			status_q  <= status_d;
			use_pix_q <= use_pix_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/circle_canvas_painter.sv =====
// ----------------------------------------------------------------------------
// Circle canvas painter
// Character canvas with clear, circle draw and pixel read items.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: one item
// m_*       out        m_tvalid/m_tready  m_tdata: one result per item
// cfg_*     in         cfg_wen            cfg_index, cfg_data
//
// One item is worked on at a time. A draw or clear scans the canvas one pixel
// per cycle through the squared distance pipeline, with a row setup step
// before each row and a pipeline drain at the end. The output register lets
// the next item be accepted while a result waits; a stalled output holds the
// following item in its last step. The canvas is not cleared by reset and
// reads as undefined until written.
// ----------------------------------------------------------------------------
module circle_canvas_painter #(
	parameter int MAX_SIDE = ccp_pkg::MAX_SIDE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// kind, shape_code, center_x, center_y, radius, draw_char, read_col, read_row
	input  logic [ccp_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status, pixel_value, zero padding
	output logic [ccp_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_wen,
	input  logic [ccp_pkg::IDX_W-1:0] cfg_index,
	input  logic [ccp_pkg::REG_W-1:0] cfg_data
);

	ccp_pkg::ccp_cmd_t  cmd;
	ccp_pkg::ccp_stat_t stat;

	ccp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ccp_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== rtl/core/ccp_checker.sv =====
// ----------------------------------------------------------------------------
// Circle canvas painter port checker
// Watches the stream ports of the painter and is bound to its top level.
// ----------------------------------------------------------------------------
`include "circle_canvas_painter_defines.svh"

module ccp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ccp_pkg::OUT_W-1:0] m_tdata
);

	`CCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`CCP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`CCP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "second transaction taken during an item")
	`CCP_ASSERT_SAME(a_pixel_only_ok, m_tvalid && (m_tdata[9:2] != 8'd0), m_tdata[1:0] == ccp_pkg::ST_OK, "pixel value with a failing status")
	`CCP_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[15:10] == 6'd0, "padding bits of a result not zero")

endmodule

bind circle_canvas_painter ccp_checker u_ccp_checker (.*);
